[rtl/watm_pkg.sv]
// ----------------------------------------------------------------------------
// watm_pkg
// Shared types and codes for the weekly alarm table matcher: the layout of
// one table entry, the tick context and the operation and status codes.
// ----------------------------------------------------------------------------
package watm_pkg;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_TOGGLE = 3'd4;
    localparam logic [2:0] OP_STOP   = 3'd5;
    localparam logic [2:0] OP_READ   = 3'd6;
    localparam logic [2:0] OP_NOP    = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [2:0] NO_DAY = 3'd7;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [6:0] days;
        logic       enabled;
        logic       done;
    } entry_t;

    typedef struct packed {
        logic       clear_done;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
    } tick_ctx_t;

endpackage

[rtl/watm_mem.sv]
// ----------------------------------------------------------------------------
// watm_mem
// Alarm table storage: one write port and one read port, with the read data
// registered so that it appears in the cycle after the read request.
// ----------------------------------------------------------------------------
module watm_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  watm_pkg::entry_t  wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output watm_pkg::entry_t  rdata
);

    watm_pkg::entry_t mem_array [DEPTH];
    watm_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/watm_tick_eval.sv]
// ----------------------------------------------------------------------------
// watm_tick_eval
// Applies one tick to one table entry: clears the fired-today flag on a new
// weekday, then checks the entry against the current weekday and time and
// marks it when it fires.
// ----------------------------------------------------------------------------
module watm_tick_eval (
    input  watm_pkg::tick_ctx_t ctx,
    input  logic                match_en,
    input  watm_pkg::entry_t    entry_in,
    output watm_pkg::entry_t    entry_out,
    output logic                hit
);

    watm_pkg::entry_t ent;
    logic [6:0]       day_bits;

    always_comb
    begin
        ent = entry_in;
        if (ctx.clear_done)
        begin
            ent.done = 1'b0;
        end
        // A weekday of seven shifts every mask bit out, so it never matches.
        day_bits = ent.days >> ctx.weekday;
        hit = match_en && ent.enabled && !ent.done && day_bits[0]
              && (ent.hour == ctx.hour) && (ent.minute == ctx.minute);
        if (hit)
        begin
            ent.done = 1'b1;
        end
        entry_out = ent;
    end

endmodule

[rtl/weekly_alarm_table_matcher_core.sv]
// ----------------------------------------------------------------------------
// weekly_alarm_table_matcher_core
// Weekly alarm table with tick matching, add, update, delete with compaction,
// enable toggle, stop ringing and entry read, built around one table memory.
//
//   Channel   Handshake          Payload
//   command   start / busy       op, slot, set_hour, set_minute, day_mask,
//                                time_valid, now_weekday, now_hour, now_minute
//   result    done (one cycle)   status, fired, fired_slot, ringing,
//                                entry_count, read_hour, read_minute,
//                                read_days, read_enabled, read_done_today
//
// Transactions that walk no entry finish at once: done is high in the cycle
// after acceptance and busy never rises. The others walk N > 0 entries, one read
// a cycle, each write-back in the cycle after its read: busy falls as done rises.
// A tick walks all held entries (none on invalid time, an empty table or a ring
// on the same weekday), a delete those above the slot, update, toggle and read one.
// After reset the table is empty and accepts at once; the receiver cannot stall.
// ----------------------------------------------------------------------------
module weekly_alarm_table_matcher_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] op,
    input  logic [3:0] slot,
    input  logic [4:0] set_hour,
    input  logic [5:0] set_minute,
    input  logic [6:0] day_mask,
    input  logic       time_valid,
    input  logic [2:0] now_weekday,
    input  logic [4:0] now_hour,
    input  logic [5:0] now_minute,
    output logic       done,
    output logic [1:0] status,
    output logic       fired,
    output logic [3:0] fired_slot,
    output logic       ringing,
    output logic [4:0] entry_count,
    output logic [4:0] read_hour,
    output logic [5:0] read_minute,
    output logic [6:0] read_days,
    output logic       read_enabled,
    output logic       read_done_today
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [0:0] {S_IDLE, S_WALK} state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [2:0]           last_day_reg, last_day_next;
    logic                 ring_reg, ring_next;
    logic [2:0]           op_reg, op_next;
    watm_pkg::entry_t     set_reg, set_next;
    watm_pkg::tick_ctx_t  ctx_reg, ctx_next;
    logic [CNT_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0]     last_reg, last_next;
    logic                 issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_addr_reg, pend_addr_next;
    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic                 fired_reg, fired_next;
    logic [3:0]           fslot_reg, fslot_next;
    watm_pkg::entry_t     read_reg, read_next;

    logic                 accept;
    logic                 slot_ok;
    logic                 day_change;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    watm_pkg::entry_t     mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;
    watm_pkg::entry_t     mem_rdata;
    watm_pkg::entry_t     tick_entry;
    logic                 tick_hit;

    watm_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    watm_tick_eval u_tick_eval (
        .ctx       (ctx_reg),
        .match_en  (!ring_reg),
        .entry_in  (mem_rdata),
        .entry_out (tick_entry),
        .hit       (tick_hit)
    );

    assign accept     = start && (state_reg == S_IDLE);
    assign slot_ok    = (8'(slot) < 8'(count_reg));
    assign day_change = (last_day_reg != now_weekday);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        last_day_next  = last_day_reg;
        ring_next      = ring_reg;
        op_next        = op_reg;
        set_next       = set_reg;
        ctx_next       = ctx_reg;
        rd_ptr_next    = rd_ptr_reg;
        last_next      = last_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        fired_next     = fired_reg;
        fslot_next     = fslot_reg;
        read_next      = read_reg;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = rd_ptr_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op;
                    set_next    = '{hour: set_hour, minute: set_minute, days: day_mask,
                                    enabled: 1'b1, done: 1'b0};
                    status_next = watm_pkg::ST_OK;
                    fired_next  = 1'b0;
                    fslot_next  = '0;
                    read_next   = '0;
                    done_next   = 1'b1;
                    case (op)
                        watm_pkg::OP_TICK:
                        begin
                            if (time_valid)
                            begin
                                last_day_next = now_weekday;
                                ctx_next = '{clear_done: day_change, weekday: now_weekday,
                                             hour: now_hour, minute: now_minute};
                                if ((count_reg != '0) && (day_change || !ring_reg))
                                begin
                                    rd_ptr_next = '0;
                                    last_next   = IDX_W'(count_reg - CNT_W'(1));
                                    issue_next  = 1'b1;
                                    state_next  = S_WALK;
                                    done_next   = 1'b0;
                                end
                            end
                        end
                        watm_pkg::OP_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_ENTRIES))
                            begin
                                status_next = watm_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[IDX_W-1:0];
                                mem_wdata  = '{hour: set_hour, minute: set_minute,
                                               days: day_mask, enabled: 1'b1, done: 1'b0};
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        watm_pkg::OP_UPDATE, watm_pkg::OP_TOGGLE, watm_pkg::OP_READ:
                        begin
                            if (!slot_ok)
                            begin
                                status_next = watm_pkg::ST_RANGE;
                            end
                            else
                            begin
                                rd_ptr_next = CNT_W'(slot);
                                last_next   = IDX_W'(slot);
                                issue_next  = 1'b1;
                                state_next  = S_WALK;
                                done_next   = 1'b0;
                            end
                        end
                        watm_pkg::OP_DELETE:
                        begin
                            if (!slot_ok)
                            begin
                                status_next = watm_pkg::ST_RANGE;
                            end
                            else if ((CNT_W'(slot) + CNT_W'(1)) == count_reg)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                rd_ptr_next = CNT_W'(slot) + CNT_W'(1);
                                last_next   = IDX_W'(count_reg - CNT_W'(1));
                                issue_next  = 1'b1;
                                state_next  = S_WALK;
                                done_next   = 1'b0;
                            end
                        end
                        watm_pkg::OP_STOP:
                        begin
                            ring_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (issue_reg)
                begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg[IDX_W-1:0];
                    if (rd_ptr_reg[IDX_W-1:0] == last_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                    end
                end
                if (pend_reg)
                begin
                    case (op_reg)
                        watm_pkg::OP_TICK:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = tick_entry;
                            if (tick_hit)
                            begin
                                ring_next  = 1'b1;
                                fired_next = 1'b1;
                                fslot_next = 4'(pend_addr_reg);
                            end
                        end
                        watm_pkg::OP_DELETE:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg - IDX_W'(1);
                        end
                        watm_pkg::OP_UPDATE:
                        begin
                            mem_we           = 1'b1;
                            mem_wdata.hour   = set_reg.hour;
                            mem_wdata.minute = set_reg.minute;
                            mem_wdata.days   = set_reg.days;
                        end
                        watm_pkg::OP_TOGGLE:
                        begin
                            mem_we            = 1'b1;
                            mem_wdata.enabled = !mem_rdata.enabled;
                        end
                        watm_pkg::OP_READ:
                        begin
                            read_next = mem_rdata;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (!issue_reg)
                    begin
                        if (op_reg == watm_pkg::OP_DELETE)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            last_day_reg  <= watm_pkg::NO_DAY;
            ring_reg      <= 1'b0;
            op_reg        <= watm_pkg::OP_TICK;
            set_reg       <= '0;
            ctx_reg       <= '0;
            rd_ptr_reg    <= '0;
            last_reg      <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            done_reg      <= 1'b0;
            status_reg    <= watm_pkg::ST_OK;
            fired_reg     <= 1'b0;
            fslot_reg     <= '0;
            read_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_day_reg  <= last_day_next;
            ring_reg      <= ring_next;
            op_reg        <= op_next;
            set_reg       <= set_next;
            ctx_reg       <= ctx_next;
            rd_ptr_reg    <= rd_ptr_next;
            last_reg      <= last_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            fired_reg     <= fired_next;
            fslot_reg     <= fslot_next;
            read_reg      <= read_next;
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign fired           = fired_reg;
    assign fired_slot      = fslot_reg;
    assign ringing         = ring_reg;
    assign entry_count     = 5'(count_reg);
    assign read_hour       = read_reg.hour;
    assign read_minute     = read_reg.minute;
    assign read_days       = read_reg.days;
    assign read_enabled    = read_reg.enabled;
    assign read_done_today = read_reg.done;

`ifndef SYNTH
    // The table never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count exceeds table depth");

    // A write-back never targets the entry being read in the same cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("memory read and write hit the same entry");

    // A tick that fired an alarm reports the alarm as ringing.
    a_fired_rings: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && fired_reg) |-> ring_reg)
        else $error("fired alarm without ringing flag");

    // A walk ends with a result strobe.
    a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && state_next == S_IDLE) |=> done_reg)
        else $error("walk finished without a result");
`endif

endmodule
